[rtl/tsmq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tsmq_pkg;

   // queue capacity and derived widths
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int VAL_W  = 32;
   localparam int TAG_W  = 10;

   // opcodes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // one stored element: value and its three tags
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [TAG_W-1:0]        x;
      logic [TAG_W-1:0]        y;
      logic [TAG_W-1:0]        z;
   } item_type;

   localparam int ITEM_W = $bits(item_type);

   // front stack slot: element plus running maximum below and at it
   typedef struct packed {
      item_type entry;
      item_type run_max;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_XFER   = 4'b0010,
      ST_POP_RD = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

`default_nettype wire

[rtl/two_stack_max_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake            fields
// req_     in   req_valid/req_stall  opcode, value, tag_x, tag_y, tag_z
// rsp_     out  rsp_valid/rsp_stall  popped_value, pop_valid, max_*, occupancy, overflow
//
// push, clear, the unused code and a pop that empties the queue or front stack go from
// idle (accepting) to finish; a pop that leaves the front non-empty adds a pop-read refill
// a pop on an empty front first walks the back stack over, one element per cycle through
// the back ram read port in the transfer state, and then pops as above
// reset is synchronous and clears only the counts and control, no ram sweep
// req_stall is high until the result loads, which waits while a stalled result is held

module two_stack_max_queue (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_opcode,
   input  wire logic signed [tsmq_pkg::VAL_W-1:0]    req_value,
   input  wire logic [tsmq_pkg::TAG_W-1:0]           req_tag_x,
   input  wire logic [tsmq_pkg::TAG_W-1:0]           req_tag_y,
   input  wire logic [tsmq_pkg::TAG_W-1:0]           req_tag_z,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [tsmq_pkg::VAL_W-1:0]         rsp_popped_value,
   output logic                                      rsp_pop_valid,
   output logic signed [tsmq_pkg::VAL_W-1:0]         rsp_max_value,
   output logic [tsmq_pkg::TAG_W-1:0]                rsp_max_x,
   output logic [tsmq_pkg::TAG_W-1:0]                rsp_max_y,
   output logic [tsmq_pkg::TAG_W-1:0]                rsp_max_z,
   output logic                                      rsp_max_valid,
   output logic [tsmq_pkg::CNT_W-1:0]                rsp_occupancy,
   output logic                                      rsp_overflow
);

   tsmq_pkg::state_type state_ff, state_in;
   logic [tsmq_pkg::CNT_W-1:0] bc_ff, bc_in;
   logic [tsmq_pkg::CNT_W-1:0] fc_ff, fc_in;
   tsmq_pkg::item_type back_max_ff, back_max_in;
   tsmq_pkg::slot_type front_top_ff, front_top_in;
   logic pend_ff, pend_in;
   logic signed [tsmq_pkg::VAL_W-1:0] popped_ff, popped_in;
   logic pop_ok_ff, pop_ok_in;
   logic ovf_ff, ovf_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [tsmq_pkg::VAL_W-1:0] rsp_popped_ff, rsp_popped_in;
   logic rsp_pop_ok_ff, rsp_pop_ok_in;
   tsmq_pkg::item_type rsp_max_ff, rsp_max_in;
   logic rsp_have_ff, rsp_have_in;
   logic [tsmq_pkg::CNT_W-1:0] rsp_occ_ff, rsp_occ_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   // ram ports
   logic                          back_we;
   logic [tsmq_pkg::ADDR_W-1:0]   back_waddr;
   tsmq_pkg::item_type            back_wdata;
   logic [tsmq_pkg::ADDR_W-1:0]   back_raddr;
   logic [tsmq_pkg::ITEM_W-1:0]   back_rdata;
   logic                          front_we;
   logic [tsmq_pkg::ADDR_W-1:0]   front_waddr;
   tsmq_pkg::slot_type            front_wdata;
   logic [tsmq_pkg::ADDR_W-1:0]   front_raddr;
   logic [tsmq_pkg::SLOT_W-1:0]   front_rdata;

   logic [tsmq_pkg::CNT_W-1:0]    bc_dec;
   logic [tsmq_pkg::CNT_W-1:0]    fc_dec2;
   logic [tsmq_pkg::CNT_W:0]      total;
   tsmq_pkg::item_type            new_item;
   tsmq_pkg::item_type            moved;
   tsmq_pkg::item_type            best;
   logic                          have;
   logic                          pop_now;

   tsmq_ram #(
      .WIDTH(tsmq_pkg::ITEM_W),
      .DEPTH(tsmq_pkg::DEPTH)
   ) u_back_ram (
      .clock  (clock),
      .wr_en  (back_we),
      .wr_addr(back_waddr),
      .wr_data(back_wdata),
      .rd_addr(back_raddr),
      .rd_data(back_rdata)
   );

   tsmq_ram #(
      .WIDTH(tsmq_pkg::SLOT_W),
      .DEPTH(tsmq_pkg::DEPTH)
   ) u_front_ram (
      .clock  (clock),
      .wr_en  (front_we),
      .wr_addr(front_waddr),
      .wr_data(front_wdata),
      .rd_addr(front_raddr),
      .rd_data(front_rdata)
   );

   // address helpers
   assign bc_dec     = bc_ff - 1'b1;
   assign fc_dec2    = fc_ff - 2'd2;
   assign total      = {1'b0, bc_ff} + {1'b0, fc_ff};
   assign back_raddr = bc_dec[tsmq_pkg::ADDR_W-1:0];
   assign front_raddr = fc_dec2[tsmq_pkg::ADDR_W-1:0];
   assign back_waddr = bc_ff[tsmq_pkg::ADDR_W-1:0];
   assign front_waddr = fc_ff[tsmq_pkg::ADDR_W-1:0];
   assign moved      = tsmq_pkg::item_type'(back_rdata);

   always_comb begin
      new_item.value = req_value;
      new_item.x     = req_tag_x;
      new_item.y     = req_tag_y;
      new_item.z     = req_tag_z;
   end

   // overall maximum, back stack wins ties
   always_comb begin
      best = '0;
      have = 1'b1;
      if (bc_ff != '0 && fc_ff != '0) begin
         if (back_max_ff.value >= front_top_ff.run_max.value) begin
            best = back_max_ff;
         end else begin
            best = front_top_ff.run_max;
         end
      end else if (bc_ff != '0) begin
         best = back_max_ff;
      end else if (fc_ff != '0) begin
         best = front_top_ff.run_max;
      end else begin
         have = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      bc_in         = bc_ff;
      fc_in         = fc_ff;
      back_max_in   = back_max_ff;
      front_top_in  = front_top_ff;
      pend_in       = pend_ff;
      popped_in     = popped_ff;
      pop_ok_in     = pop_ok_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_pop_ok_in = rsp_pop_ok_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_have_in   = rsp_have_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      back_we       = 1'b0;
      back_wdata    = new_item;
      front_we      = 1'b0;
      front_wdata   = front_top_ff;
      pop_now       = 1'b0;

      // result taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         tsmq_pkg::ST_IDLE: begin
            if (req_valid) begin
               popped_in = '0;
               pop_ok_in = 1'b0;
               ovf_in    = 1'b0;
               state_in  = tsmq_pkg::ST_FINISH;
               case (req_opcode)
                  tsmq_pkg::OP_PUSH: begin
                     if (total >= (tsmq_pkg::CNT_W + 1)'(tsmq_pkg::DEPTH)) begin
                        ovf_in = 1'b1;
                     end else begin
                        back_we = 1'b1;
                        bc_in   = bc_ff + 1'b1;
                        // older entry kept on a tie
                        if (bc_ff != '0 && back_max_ff.value >= new_item.value) begin
                           back_max_in = back_max_ff;
                        end else begin
                           back_max_in = new_item;
                        end
                     end
                  end
                  tsmq_pkg::OP_POP: begin
                     if (fc_ff != '0) begin
                        pop_now = 1'b1;
                     end else if (bc_ff != '0) begin
                        state_in = tsmq_pkg::ST_XFER;
                        pend_in  = 1'b0;
                     end
                  end
                  tsmq_pkg::OP_CLEAR: begin
                     bc_in = '0;
                     fc_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         tsmq_pkg::ST_XFER: begin
            // element read last cycle lands on the front stack
            if (pend_ff) begin
               front_wdata.entry = moved;
               if (fc_ff != '0 && front_top_ff.run_max.value >= moved.value) begin
                  front_wdata.run_max = front_top_ff.run_max;
               end else begin
                  front_wdata.run_max = moved;
               end
               front_we     = 1'b1;
               front_top_in = front_wdata;
               fc_in        = fc_ff + 1'b1;
            end
            // next read from the back stack top
            if (bc_ff != '0) begin
               bc_in   = bc_dec;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  pop_now = 1'b1;
               end
            end
         end

         tsmq_pkg::ST_POP_RD: begin
            front_top_in = tsmq_pkg::slot_type'(front_rdata);
            state_in     = tsmq_pkg::ST_FINISH;
         end

         tsmq_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_popped_in = popped_ff;
               rsp_pop_ok_in = pop_ok_ff;
               rsp_max_in    = best;
               rsp_have_in   = have;
               rsp_occ_in    = total[tsmq_pkg::CNT_W-1:0];
               rsp_ovf_in    = ovf_ff;
               state_in      = tsmq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tsmq_pkg::ST_IDLE;
         end
      endcase

      // pop from the cached front top, refill it from the ram if more remain
      if (pop_now) begin
         popped_in = front_top_ff.entry.value;
         pop_ok_in = 1'b1;
         fc_in     = fc_ff - 1'b1;
         if (fc_ff > (tsmq_pkg::CNT_W)'(1)) begin
            state_in = tsmq_pkg::ST_POP_RD;
         end else begin
            state_in = tsmq_pkg::ST_FINISH;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsmq_pkg::ST_IDLE;
         bc_ff        <= '0;
         fc_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bc_ff        <= bc_in;
         fc_ff        <= fc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      back_max_ff   <= back_max_in;
      front_top_ff  <= front_top_in;
      popped_ff     <= popped_in;
      pop_ok_ff     <= pop_ok_in;
      ovf_ff        <= ovf_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_pop_ok_ff <= rsp_pop_ok_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_have_ff   <= rsp_have_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   // ports
   assign req_stall        = (state_ff != tsmq_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_pop_valid    = rsp_pop_ok_ff;
   assign rsp_max_value    = rsp_max_ff.value;
   assign rsp_max_x        = rsp_max_ff.x;
   assign rsp_max_y        = rsp_max_ff.y;
   assign rsp_max_z        = rsp_max_ff.z;
   assign rsp_max_valid    = rsp_have_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

`default_nettype wire

[rtl/tsmq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tsmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
